// ===== design/bfcr_pkg.sv =====
// Shared types and constants for the byte FIFO with commit and rollback.
package bfcr_pkg;

    // Fixed field widths and the default ring depth
    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 10;
    localparam int DEF_DEPTH = 1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRY_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT_WR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ABORT_WR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRY_READ    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COMMIT_RD   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ROLLBACK_RD = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_we;
        logic clear;
        logic commit_wr;
        logic abort_wr;
        logic commit_rd;
        logic rollback_rd;
        logic wr_en;
        logic rd_en;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic wr_ok;
        logic rd_ok;
    } t_dp_stat;

endpackage

// ===== design/bfcr_ctrl.sv =====
// Controller: command decode, accept handshake and result strobe sequencing.
module bfcr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bfcr_pkg::CMD_W-1:0]  i_cmd,
    input  logic                        i_cfg_we,
    input  bfcr_pkg::t_dp_stat          i_stat,
    output bfcr_pkg::t_dp_cmd           o_cmd,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic                        o_done_res
);
    import bfcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } t_state;

    t_state  r_state, n_state;
    logic    r_done,  n_done;
    logic    accept;
    t_dp_cmd cmd;

    // Hold off new words only while reset is applied
    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    // Decode the accepted word into datapath commands
    always_comb begin
        cmd        = '0;
        cmd.cfg_we = i_cfg_we;
        n_done     = 1'b0;
        if (accept) begin
            case (i_cmd)
                CMD_CLEAR:       cmd.clear       = 1'b1;
                CMD_TRY_WRITE: begin
                    cmd.wr_en = i_stat.wr_ok;
                    n_done    = i_stat.wr_ok;
                end
                CMD_COMMIT_WR:   cmd.commit_wr   = 1'b1;
                CMD_ABORT_WR:    cmd.abort_wr    = 1'b1;
                CMD_TRY_READ: begin
                    cmd.rd_en = i_stat.rd_ok;
                    n_done    = i_stat.rd_ok;
                end
                CMD_COMMIT_RD:   cmd.commit_rd   = 1'b1;
                CMD_ROLLBACK_RD: cmd.rollback_rd = 1'b1;
                default:         cmd             = cmd;
            endcase
        end
    end

    assign o_cmd = cmd;

    // Advance to the result cycle on every accepted word
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = accept ? ST_RESP : ST_IDLE;
            ST_RESP: n_state = accept ? ST_RESP : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_valid    = (r_state == ST_RESP);
    assign o_done_res = o_valid && r_done;

`ifndef SYNTHESIS
    a_valid_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("result strobe missing after accepted word");
    a_no_double_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_en && cmd.rd_en))
        else $error("write and read issued together");
    a_done_needs_try: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> (accept && (i_cmd == CMD_TRY_WRITE || i_cmd == CMD_TRY_READ)))
        else $error("done flagged for a non-try command");
`endif

endmodule

// ===== design/bfcr_dp.sv =====
// Datapath: byte store, committed and speculative pointers, status counts.
module bfcr_dp #(
    parameter int DEPTH = bfcr_pkg::DEF_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfcr_pkg::t_dp_cmd           i_cmd,
    input  logic [bfcr_pkg::BYTE_W-1:0] i_write_byte,
    input  logic [bfcr_pkg::CFG_W-1:0]  i_cfg_wdata,
    output bfcr_pkg::t_dp_stat          o_stat,
    output logic [bfcr_pkg::BYTE_W-1:0] o_read_byte,
    output logic [bfcr_pkg::CNT_W-1:0]  o_used_count,
    output logic [bfcr_pkg::CNT_W-1:0]  o_free_count,
    output logic                        o_is_empty,
    output logic                        o_is_full
);
    import bfcr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              r_rd_hit;

    logic [CW-1:0] r_cap;
    logic [PW-1:0] r_head, r_tail, r_spec_head, r_spec_tail;
    logic [PW-1:0] n_head, n_tail, n_spec_head, n_spec_tail;

    logic [PW-1:0] adv_spec_tail, adv_spec_head, adv_tail;
    logic [CW-1:0] used, free_cnt;
    logic [KW+CFG_W-1:0] cfg_ext;
    logic [KW-1:0]       cfg_val;
    logic [KW-1:0]       cfg_clamp;
    logic [CW+CNT_W-1:0] used_ext, free_ext;

    // Step a pointer by one, wrapping at the ring size
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= cap) ? '0 : n[PW-1:0];
    endfunction

    assign adv_spec_tail = advance(r_spec_tail, r_cap);
    assign adv_spec_head = advance(r_spec_head, r_cap);
    assign adv_tail      = advance(r_tail, r_cap);

    assign o_stat.wr_ok = (adv_spec_tail != r_head);
    assign o_stat.rd_ok = (r_spec_head != r_tail);

    // Clamp the written ring size into the supported range
    assign cfg_ext   = {{KW{1'b0}}, i_cfg_wdata};
    assign cfg_val   = cfg_ext[KW-1:0];
    assign cfg_clamp = (cfg_val < KW'(2))     ? KW'(2) :
                       (cfg_val > KW'(DEPTH)) ? KW'(DEPTH) : cfg_val;

    // Select the next pointer values
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_spec_head = r_spec_head;
        n_spec_tail = r_spec_tail;
        if (i_cmd.cfg_we || i_cmd.clear) begin
            n_head      = '0;
            n_tail      = '0;
            n_spec_head = '0;
            n_spec_tail = '0;
        end else begin
            if (i_cmd.wr_en)       n_spec_tail = adv_spec_tail;
            if (i_cmd.abort_wr)    n_spec_tail = r_tail;
            if (i_cmd.commit_wr)   n_tail      = r_spec_tail;
            if (i_cmd.rd_en)       n_spec_head = adv_spec_head;
            if (i_cmd.rollback_rd) n_spec_head = r_head;
            if (i_cmd.commit_rd)   n_head      = r_spec_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CW'(DEPTH);
            r_head      <= '0;
            r_tail      <= '0;
            r_spec_head <= '0;
            r_spec_tail <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) r_cap <= cfg_clamp[CW-1:0];
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_spec_head <= n_spec_head;
            r_spec_tail <= n_spec_tail;
            r_rd_hit    <= i_cmd.rd_en;
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) mem[r_spec_tail] <= i_write_byte;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_rdata <= mem[r_spec_head];
    end

    assign o_read_byte = r_rd_hit ? r_rdata : '0;

    // Report the committed fill state
    assign used     = (r_tail >= r_head) ? (CW'(r_tail) - CW'(r_head))
                                         : (CW'(r_tail) + r_cap - CW'(r_head));
    assign free_cnt = r_cap - CW'(1) - used;
    assign used_ext = {{CNT_W{1'b0}}, used};
    assign free_ext = {{CNT_W{1'b0}}, free_cnt};

    assign o_used_count = used_ext[CNT_W-1:0];
    assign o_free_count = free_ext[CNT_W-1:0];
    assign o_is_empty   = (r_head == r_tail);
    assign o_is_full    = (adv_tail == r_head);

`ifndef SYNTHESIS
    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_tail) < r_cap) && (CW'(r_spec_tail) < r_cap) && (CW'(r_spec_head) < r_cap))
        else $error("pointer beyond ring size");
    a_write_moves_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && !i_cmd.cfg_we) |=> (r_spec_tail != $past(r_spec_tail)))
        else $error("speculative tail did not advance on write");
    a_read_hit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |=> r_rd_hit)
        else $error("read data not flagged after read");
`endif

endmodule

// ===== design/byte_fifo_with_commit_rollback.sv =====
// Top level of the byte FIFO with commit and rollback.
// Usage: one command word is taken per clock whenever start is high and busy is low;
// busy is high only while reset is applied. Each word yields exactly one result,
// strobed by o_valid in the cycle after acceptance, so a steady stream sees one
// result per clock, each read byte coming from the registered read port of
// the byte store. The receiver cannot stall: results must be taken as they appear.
// Writing the ring size (clamped to 2..DEPTH) clears all pointers; do it only
// when no result is outstanding.
module byte_fifo_with_commit_rollback #(
    parameter int DEPTH = bfcr_pkg::DEF_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bfcr_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bfcr_pkg::BYTE_W-1:0] i_write_byte,
    input  logic                        i_cfg_we,
    input  logic [bfcr_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    output logic [bfcr_pkg::BYTE_W-1:0] o_read_byte,
    output logic                        o_done_res,
    output logic [bfcr_pkg::CNT_W-1:0]  o_used_count,
    output logic [bfcr_pkg::CNT_W-1:0]  o_free_count,
    output logic                        o_is_empty,
    output logic                        o_is_full
);
    import bfcr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bfcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_done_res (o_done_res)
    );

    bfcr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_write_byte (i_write_byte),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_stat       (dp_stat),
        .o_read_byte  (o_read_byte),
        .o_used_count (o_used_count),
        .o_free_count (o_free_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

endmodule

// ===== verif/byte_fifo_with_commit_rollback_tb.sv =====
// Self-checking testbench for the byte FIFO with commit and rollback.
`timescale 1ns / 1ps

module byte_fifo_with_commit_rollback_tb;
    import bfcr_pkg::*;

    // Unused command code, reports status only
    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

    // One status word as the block reports it
    typedef struct packed {
        logic [BYTE_W-1:0] rbyte;
        logic              done;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  free;
        logic              empty;
        logic              full;
    } t_status;

    // Ring predictor plus the queue of status words still to arrive
    class ring_scoreboard;
        logic [CFG_W-1:0]  cap;
        logic [CNT_W-1:0]  hd, tl, sp_hd, sp_tl;
        logic [BYTE_W-1:0] store [DEF_DEPTH];
        t_status           status_q[$];
        int                errors;

        function new();
            cap    = CFG_W'(DEF_DEPTH);
            errors = 0;
            foreach (store[i]) store[i] = '0;
            clear_ptrs();
        endfunction

        function void clear_ptrs();
            hd    = '0;
            tl    = '0;
            sp_hd = '0;
            sp_tl = '0;
        endfunction

        // Clamp the ring size and drop all pointers
        function void set_capacity(logic [CFG_W-1:0] v);
            if (v < 2) cap = CFG_W'(2);
            else if (v > DEF_DEPTH) cap = CFG_W'(DEF_DEPTH);
            else cap = v;
            clear_ptrs();
        endfunction

        // Advance a pointer, wrapping by compare with the ring size
        function logic [CNT_W-1:0] step_ptr(logic [CNT_W-1:0] p);
            logic [CFG_W-1:0] n;
            n = {1'b0, p} + 1'b1;
            return (n >= cap) ? '0 : n[CNT_W-1:0];
        endfunction

        // Predict the status word of one accepted command
        function void note_cmd(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wbyte);
            t_status          s;
            logic [CFG_W-1:0] used;
            logic [CFG_W-1:0] fr;
            s = '0;
            case (cmd)
                CMD_CLEAR: clear_ptrs();
                CMD_TRY_WRITE: begin
                    if (step_ptr(sp_tl) != hd) begin
                        store[sp_tl] = wbyte;
                        sp_tl = step_ptr(sp_tl);
                        s.done = 1'b1;
                    end
                end
                CMD_COMMIT_WR: tl = sp_tl;
                CMD_ABORT_WR:  sp_tl = tl;
                CMD_TRY_READ: begin
                    if (sp_hd != tl) begin
                        s.rbyte = store[sp_hd];
                        sp_hd = step_ptr(sp_hd);
                        s.done = 1'b1;
                    end
                end
                CMD_COMMIT_RD:   hd = sp_hd;
                CMD_ROLLBACK_RD: sp_hd = hd;
                default: ;
            endcase
            if (tl >= hd) used = {1'b0, tl} - {1'b0, hd};
            else used = {1'b0, tl} + cap - {1'b0, hd};
            fr      = cap - 1'b1 - used;
            s.used  = used[CNT_W-1:0];
            s.free  = fr[CNT_W-1:0];
            s.empty = (hd == tl);
            s.full  = (step_ptr(tl) == hd);
            status_q.push_back(s);
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one status word with the oldest prediction
        function void check_status(t_status got);
            t_status want;
            if (status_q.size() == 0) begin
                $display("%0t: status word with none predicted, actual %h", $time, got);
                errors++;
                return;
            end
            want = status_q.pop_front();
            cmp_field("read_byte", want.rbyte, got.rbyte);
            cmp_field("done_res", want.done, got.done);
            cmp_field("used_count", want.used, got.used);
            cmp_field("free_count", want.free, got.free);
            cmp_field("is_empty", want.empty, got.empty);
            cmp_field("is_full", want.full, got.full);
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   i_cmd        = CMD_NOP;
    logic [BYTE_W-1:0]  i_write_byte = '0;
    logic               i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata  = '0;
    logic               o_valid;
    logic [BYTE_W-1:0]  o_read_byte;
    logic               o_done_res;
    logic [CNT_W-1:0]   o_used_count;
    logic [CNT_W-1:0]   o_free_count;
    logic               o_is_empty;
    logic               o_is_full;

    ring_scoreboard sb = new();
    int burst_left = 0;

    byte_fifo_with_commit_rollback u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_write_byte (i_write_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_read_byte  (o_read_byte),
        .o_done_res   (o_done_res),
        .o_used_count (o_used_count),
        .o_free_count (o_free_count),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check results first, then note the word accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_status({o_read_byte, o_done_res, o_used_count, o_free_count,
                             o_is_empty, o_is_full});
        if (i_rst_n && start && !busy)
            sb.note_cmd(i_cmd, i_write_byte);
    end

    // Hold start low for a number of cycles
    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Send one command word, opening a new burst, mostly after a random gap
    task automatic issue(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] wbyte);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 5));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_write_byte <= wbyte;
        do @(posedge i_clk); while (busy);
    endtask

    // Let every predicted word arrive, then the pipeline settle
    task automatic drain();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_capacity(logic [CFG_W-1:0] v);
        drain();
        sb.set_capacity(v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    // Mostly well-formed write and read transactions, some noise
    task automatic run_random(int n_items);
        int sent;
        int r;
        int len;
        int hi;
        logic wr;
        sent = 0;
        while (sent < n_items) begin
            r  = $urandom_range(0, 99);
            hi = (sb.cap < 16) ? int'(sb.cap) + 1 : 16;
            if (r < 12) begin
                issue(CMD_W'($urandom_range(0, 7)), BYTE_W'($urandom));
                sent++;
            end else begin
                wr  = (r < 56);
                len = $urandom_range(1, hi);
                repeat (len) begin
                    issue(wr ? CMD_TRY_WRITE : CMD_TRY_READ, BYTE_W'($urandom));
                    sent++;
                end
                if (wr) issue(($urandom_range(0, 4) != 0) ? CMD_COMMIT_WR : CMD_ABORT_WR,
                              BYTE_W'($urandom));
                else issue(($urandom_range(0, 3) != 0) ? CMD_COMMIT_RD : CMD_ROLLBACK_RD,
                           BYTE_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] caps [10];
        caps = '{11'd0, 11'd3, 11'd1, 11'd2047, 11'd5, 11'd1025, 11'd17, 11'd2,
                 CFG_W'($urandom_range(4, 64)), 11'd1024};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty reads, uncommitted data, commit, rollback, abort
        issue(CMD_TRY_READ, 8'h00);
        issue(CMD_COMMIT_RD, 8'h00);
        issue(CMD_ROLLBACK_RD, 8'h00);
        issue(CMD_TRY_WRITE, 8'h00);
        issue(CMD_TRY_WRITE, 8'hFF);
        issue(CMD_TRY_READ, 8'h00);
        issue(CMD_COMMIT_WR, 8'hFF);
        issue(CMD_TRY_READ, 8'hFF);
        issue(CMD_ROLLBACK_RD, 8'h00);
        issue(CMD_TRY_READ, 8'h00);
        issue(CMD_TRY_READ, 8'h00);
        issue(CMD_TRY_READ, 8'h00);
        issue(CMD_COMMIT_RD, 8'h00);
        issue(CMD_TRY_WRITE, 8'hA5);
        issue(CMD_ABORT_WR, 8'h00);
        issue(CMD_COMMIT_WR, 8'h00);
        issue(CMD_NOP, 8'hFF);
        issue(CMD_TRY_WRITE, 8'h5A);
        issue(CMD_COMMIT_WR, 8'h00);
        issue(CMD_CLEAR, 8'h00);

        // Directed: smallest ring, full on write, ring size write clears data
        apply_capacity(11'd0);
        issue(CMD_TRY_WRITE, 8'h11);
        issue(CMD_TRY_WRITE, 8'h22);
        issue(CMD_COMMIT_WR, 8'h00);
        issue(CMD_TRY_WRITE, 8'h33);
        apply_capacity(11'd2047);
        issue(CMD_TRY_READ, 8'h00);

        foreach (caps[i]) begin
            apply_capacity(caps[i]);
            run_random(130);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("byte_fifo_with_commit_rollback: match");
        end else begin
            $display("byte_fifo_with_commit_rollback: mismatch");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("byte_fifo_with_commit_rollback: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/bfcr_pkg.sv
design/bfcr_ctrl.sv
design/bfcr_dp.sv
design/byte_fifo_with_commit_rollback.sv
verif/byte_fifo_with_commit_rollback_tb.sv
